>>> src/cesd_pkg.sv
package cesd_pkg;

   localparam int MAX_RES   = 3;
   localparam int RSP_DEPTH = 4;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_HEX    = 3'd2;
   localparam logic [2:0] MODE_OCT    = 3'd3;
   localparam logic [2:0] MODE_UTF8   = 3'd4;
   localparam logic [2:0] MODE_DROP   = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ESC    = 3'd1;
   localparam logic [2:0] ST_BAD_HEX    = 3'd2;
   localparam logic [2:0] ST_BAD_UTF8   = 3'd3;
   localparam logic [2:0] ST_NOT_QUOTED = 3'd4;

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_A         = 8'h61;
   localparam logic [7:0] CH_V         = 8'h76;
   localparam logic [7:0] CH_X         = 8'h78;

   localparam logic [7:0] UTF8_MASK2 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_MASK3 = 8'hF0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_MASK4 = 8'hF8;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

   typedef struct packed {
      logic [2:0] status;
      logic       eos;
      logic       has_byte;
      logic [7:0] data;
   } res_item_type;

   typedef struct packed {
      logic [1:0]                       count;
      res_item_type [MAX_RES-1:0]       item;
   } res_list_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] acc;
      logic [1:0] digits;
      logic [1:0] utf_rem;
      logic [7:0] held_byte;
      logic       held_valid;
      logic [1:0] emitted;
   } str_state_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_value(input logic [7:0] b);
      hex_type h;
      h = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.valid = 1'b1;
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.valid = 1'b1;
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.valid = 1'b1;
         h.value = 4'(b - 8'h37);
      end
      return h;
   endfunction

endpackage

>>> src/cesd_step.sv
module cesd_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  logic                  strip_quotes,
   output cesd_pkg::res_list_type results
);
   import cesd_pkg::*;

   str_state_type state_ff;
   str_state_type state_in;
   res_list_type  list_w;
   hex_type       hex_w;
   logic          done_w;

   function automatic void push(input logic [7:0] b, input logic has, input logic eos,
                                input logic [2:0] st, inout res_list_type rl);
      if (rl.count < 2'(MAX_RES)) begin
         rl.item[rl.count].data     = b;
         rl.item[rl.count].has_byte = has;
         rl.item[rl.count].eos      = eos;
         rl.item[rl.count].status   = st;
         rl.count                   = rl.count + 2'd1;
      end
   endfunction

   function automatic void emit(input logic strip, input logic [7:0] b,
                                inout str_state_type s, inout res_list_type rl);
      if (strip) begin
         // first decoded byte is the opening quote; later ones lag by one
         if (s.emitted == 2'd0) begin
            s.emitted = 2'd1;
         end else begin
            if (s.held_valid) begin
               push(s.held_byte, 1'b1, 1'b0, ST_OK, rl);
            end
            s.held_byte  = b;
            s.held_valid = 1'b1;
            s.emitted    = 2'd2;
         end
      end else begin
         push(b, 1'b1, 1'b0, ST_OK, rl);
         if (s.emitted != 2'd2) begin
            s.emitted = s.emitted + 2'd1;
         end
      end
   endfunction

   function automatic void fail(input logic [2:0] st, input logic last,
                                inout str_state_type s, inout res_list_type rl);
      push(8'h00, 1'b0, 1'b1, st, rl);
      s = '0;
      if (!last) begin
         s.mode = MODE_DROP;
      end
   endfunction

   function automatic void finish(input logic strip, inout str_state_type s,
                                  inout res_list_type rl);
      logic [2:0] st;
      st = (strip && s.emitted != 2'd2) ? ST_NOT_QUOTED : ST_OK;
      push(8'h00, 1'b0, 1'b1, st, rl);
      s = '0;
   endfunction

   // decode a byte at a character start; returns 1 if it ended the string
   function automatic logic plain(input logic strip, input logic [7:0] b, input logic last,
                                  inout str_state_type s, inout res_list_type rl);
      logic [1:0] n;
      logic       bad;
      logic       ended;
      n     = 2'd0;
      bad   = 1'b0;
      ended = 1'b0;
      if (b[7]) begin
         if ((b & UTF8_MASK2) == UTF8_LEAD2) begin
            n = 2'd1;
         end else if ((b & UTF8_MASK3) == UTF8_LEAD3) begin
            n = 2'd2;
         end else if ((b & UTF8_MASK4) == UTF8_LEAD4) begin
            n = 2'd3;
         end else begin
            bad = 1'b1;
         end
         if (bad) begin
            fail(ST_BAD_UTF8, last, s, rl);
            ended = 1'b1;
         end else begin
            emit(strip, b, s, rl);
            s.utf_rem = n;
            s.mode    = MODE_UTF8;
         end
      end else if (b == CH_BACKSLASH) begin
         s.mode = MODE_ESC;
      end else begin
         emit(strip, b, s, rl);
      end
      return ended;
   endfunction

   always_comb begin
      state_in = state_ff;
      list_w   = '0;
      done_w   = 1'b0;
      hex_w    = hex_value(in_byte);
      unique case (state_in.mode)
         MODE_DROP: begin
            if (in_last) begin
               state_in = '0;
            end
            done_w = 1'b1;
         end
         MODE_UTF8: begin
            emit(strip_quotes, in_byte, state_in, list_w);
            state_in.utf_rem = state_in.utf_rem - 2'd1;
            if (state_in.utf_rem == 2'd0) begin
               state_in.mode = MODE_NORMAL;
            end
         end
         MODE_ESC: begin
            state_in.mode = MODE_NORMAL;
            unique case (in_byte)
               CH_N: emit(strip_quotes, 8'h0A, state_in, list_w);
               CH_T: emit(strip_quotes, 8'h09, state_in, list_w);
               CH_R: emit(strip_quotes, 8'h0D, state_in, list_w);
               CH_B: emit(strip_quotes, 8'h08, state_in, list_w);
               CH_F: emit(strip_quotes, 8'h0C, state_in, list_w);
               CH_A: emit(strip_quotes, 8'h07, state_in, list_w);
               CH_V: emit(strip_quotes, 8'h0B, state_in, list_w);
               CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE: begin
                  emit(strip_quotes, in_byte, state_in, list_w);
               end
               CH_X: begin
                  state_in.mode   = MODE_HEX;
                  state_in.acc    = 8'h00;
                  state_in.digits = 2'd0;
               end
               default: begin
                  if (in_byte[7:3] == 5'b00110) begin
                     state_in.mode   = MODE_OCT;
                     state_in.acc    = {5'd0, in_byte[2:0]};
                     state_in.digits = 2'd1;
                  end else begin
                     fail(ST_BAD_ESC, in_last, state_in, list_w);
                     done_w = 1'b1;
                  end
               end
            endcase
         end
         MODE_HEX: begin
            if (!hex_w.valid) begin
               fail(ST_BAD_HEX, in_last, state_in, list_w);
               done_w = 1'b1;
            end else begin
               state_in.acc    = {state_in.acc[3:0], hex_w.value};
               state_in.digits = state_in.digits + 2'd1;
               if (state_in.digits == 2'd2) begin
                  emit(strip_quotes, state_in.acc, state_in, list_w);
                  state_in.mode   = MODE_NORMAL;
                  state_in.acc    = 8'h00;
                  state_in.digits = 2'd0;
               end
            end
         end
         MODE_OCT: begin
            if (in_byte[7:3] == 5'b00110) begin
               state_in.acc    = {state_in.acc[4:0], in_byte[2:0]};
               state_in.digits = state_in.digits + 2'd1;
               if (state_in.digits == 2'd3) begin
                  emit(strip_quotes, state_in.acc, state_in, list_w);
                  state_in.mode   = MODE_NORMAL;
                  state_in.acc    = 8'h00;
                  state_in.digits = 2'd0;
               end
            end else begin
               // octal value goes out first, then the byte decodes afresh
               emit(strip_quotes, state_in.acc, state_in, list_w);
               state_in.mode   = MODE_NORMAL;
               state_in.acc    = 8'h00;
               state_in.digits = 2'd0;
               done_w = plain(strip_quotes, in_byte, in_last, state_in, list_w);
            end
         end
         default: begin
            state_in.mode = MODE_NORMAL;
            done_w = plain(strip_quotes, in_byte, in_last, state_in, list_w);
         end
      endcase

      if (!done_w && in_last) begin
         if (state_in.mode == MODE_HEX || state_in.mode == MODE_OCT) begin
            emit(strip_quotes, state_in.acc, state_in, list_w);
         end else if (state_in.mode == MODE_ESC) begin
            emit(strip_quotes, CH_BACKSLASH, state_in, list_w);
         end
         if (state_in.mode == MODE_UTF8) begin
            fail(ST_BAD_UTF8, 1'b1, state_in, list_w);
         end else begin
            finish(strip_quotes, state_in, list_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   assign results = list_w;

endmodule

>>> src/c_escape_sequence_decoder.sv
// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata[7:0] in_byte, tlast in_last
// rsp       out  rsp_tvalid/rsp_tready  tdata[7:0] out_byte, tdata[10:8] status,
//                                       tuser has_byte, tlast end_of_string
// csr       in   csr_valid/csr_ready    csr_data strip_quotes
//
// one raw byte per cycle, room permitting: input register, decode logic, 4-entry result queue
// a byte yields 0 to 3 beats; it leaves the input register once at most one beat is queued
// one-beat bytes flow at one per cycle while rsp_tready holds; more beats stall the next byte
// rsp stalls fill the queue and then back up into req_tready
// synchronous reset clears the string state, the queue and strip_quotes; csr is always ready
module c_escape_sequence_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] status, rest zero
   output logic        rsp_tuser,   // has_byte
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import cesd_pkg::*;

   logic         strip_ff;
   logic         in_valid_ff;
   logic         in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         advance;
   logic         req_accept;
   logic         rsp_pop;
   res_list_type results;
   res_item_type queue_ff [RSP_DEPTH];
   res_item_type head;
   logic [1:0]   wr_ptr_ff;
   logic [1:0]   rd_ptr_ff;
   logic [2:0]   count_ff;
   logic [2:0]   count_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= 1'b0;
      end else if (csr_valid) begin
         strip_ff <= csr_data;
      end
   end

   // input stage moves on only when the queue has room for a worst-case byte
   assign advance     = in_valid_ff && (count_ff <= 3'(RSP_DEPTH - MAX_RES));
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   cesd_step u_step (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .in_byte      (in_byte_ff),
      .in_last      (in_last_ff),
      .strip_quotes (strip_ff),
      .results      (results)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < results.count) begin
               queue_ff[wr_ptr_ff + 2'(k)] <= results.item[k];
            end
         end
      end
   end

   assign rsp_pop  = rsp_tvalid && rsp_tready;
   assign count_in = count_ff + (advance ? {1'b0, results.count} : 3'd0)
                     - {2'd0, rsp_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (advance) begin
            wr_ptr_ff <= wr_ptr_ff + results.count;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_in;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {5'd0, head.status, head.data};
   assign rsp_tuser  = head.has_byte;
   assign rsp_tlast  = head.eos;

`ifndef SYNTH
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(RSP_DEPTH))
      else $error("result queue overflow");

   a_end_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser)
      else $error("end beat carries a byte");

   a_status_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[10:8] == ST_OK)
      else $error("error status on a data beat");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input stage lost a byte");
`endif

endmodule
